// ===== rtl/ldc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU descriptor cache package
// Shared types and constants for the cache controller and its entry cells.
// ----------------------------------------------------------------------------
package ldc_pkg;

	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_W      = KEY_WORDS * WORD_W;
	localparam int unsigned CAP_W      = 7;
	localparam int unsigned SLOT_OUT_W = 6;
	localparam int unsigned EVICT_W    = 7;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned OUT_W      = SLOT_OUT_W + EVICT_W + 2 * CNT_W;
	localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HIT,
		OP_MISS
	} cell_op_t;

	typedef struct packed {
		logic     compare;
		cell_op_t op;
	} cell_cmd_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic evict;
	} cell_rep_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_SCAN,
		ST_UPDATE
	} ctrl_state_t;

endpackage

// ===== rtl/lru_descriptor_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU descriptor cache unit
// Fully associative least-recently-used cache built as a row of entry cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         tdata: key_word_0..key_word_3; tuser: compare_flag
// m_*      out        tdata: slot_index, evicted_count, hit_total, miss_total
// cfg_*    in         capacity_limit
//
// A lookup runs through accept, a parallel compare, a token walk over all
// ENTRIES cells, and an update step.
// The scan token moving one cell per cycle sets the lookup length.
// Reset clears valid bits, ranks, counters and sets the capacity to 64.
// A stalled result holds the update cycle until the output register frees.
// ----------------------------------------------------------------------------
module lru_descriptor_cache_unit #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key_word_0, key_word_1, key_word_2, key_word_3
	input  logic [ldc_pkg::KEY_W-1:0]       s_tdata,
	// compare_flag
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slot_index, evicted_count, hit_total, miss_total, zero pad
	output logic [ldc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// was_hit
	output logic                            m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ldc_pkg::CAP_W-1:0]       cfg_data
);
	import ldc_pkg::*;

	localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned SW = RW;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned XW = RW + 8;

	ctrl_state_t      state_q, state_d;
	logic [CAP_W-1:0] cap_q;
	logic [KEY_W-1:0] key_q;
	logic             flag_q;
	logic [SW-1:0]    idx_q;
	logic             hit_found_q;
	logic [SW-1:0]    hit_slot_q;
	logic [RW-1:0]    hit_rank_q;
	logic             free_found_q;
	logic [SW-1:0]    free_slot_q;
	logic [CW-1:0]    evict_cnt_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic             out_valid_q;
	logic             out_hit_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	cell_cmd_t        cmd;
	logic [XW-1:0]    cap_x;
	logic [RW-1:0]    cap_m1;
	logic [SW-1:0]    wr_slot;
	logic [ENTRIES:0] tok;
	cell_rep_t        rep   [ENTRIES];
	logic [RW-1:0]    rrank [ENTRIES];
	cell_rep_t        rep_or;
	logic [RW-1:0]    rank_or;
	logic             out_free;
	logic [CNT_W-1:0] hit_next;
	logic [CNT_W-1:0] miss_next;
	logic [SW+SLOT_OUT_W-1:0] slot_ext;
	logic [CW+EVICT_W-1:0]    evict_ext;

	always_comb begin
		cap_x = XW'(cap_q);
		if (cap_x == '0) begin
			cap_x = XW'(1);
		end
		if (cap_x > XW'(ENTRIES)) begin
			cap_x = XW'(ENTRIES);
		end
	end
	assign cap_m1 = RW'(cap_x - XW'(1));

	assign tok[0]  = (state_q == ST_COMPARE);
	assign wr_slot = free_slot_q;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ldc_cell #(.RW(RW), .SW(SW), .IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.key      (key_q),
			.flag     (flag_q),
			.hit_rank (hit_rank_q),
			.cap_m1   (cap_m1),
			.wr_slot  (wr_slot),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1]),
			.rep      (rep[g]),
			.rep_rank (rrank[g])
		);
	end

	always_comb begin
		rep_or  = '0;
		rank_or = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rep_or  = rep_or | rep[i];
			rank_or = rank_or | rrank[i];
		end
	end

	assign out_free  = !out_valid_q || m_tready;
	assign hit_next  = hit_cnt_q + CNT_W'(1);
	assign miss_next = miss_cnt_q + CNT_W'(1);

	always_comb begin
		state_d     = state_q;
		cmd.compare = 1'b0;
		cmd.op      = OP_NONE;
		s_tready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == SW'(ENTRIES - 1)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.op  = hit_found_q ? OP_HIT : OP_MISS;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_RESET;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			evict_cnt_q  <= '0;
			hit_cnt_q    <= '0;
			miss_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (state_q == ST_UPDATE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COMPARE: begin
					idx_q        <= '0;
					hit_found_q  <= 1'b0;
					free_found_q <= 1'b0;
					evict_cnt_q  <= '0;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (rep_or.hit) begin
						hit_found_q <= 1'b1;
					end
					if (rep_or.free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (rep_or.evict) begin
						evict_cnt_q <= evict_cnt_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						if (hit_found_q) begin
							hit_cnt_q <= hit_next;
						end else begin
							miss_cnt_q <= miss_next;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign slot_ext  = {{SLOT_OUT_W{1'b0}}, (hit_found_q ? hit_slot_q : free_slot_q)};
	assign evict_ext = {{EVICT_W{1'b0}}, (hit_found_q ? CW'(0) : evict_cnt_q)};

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_q  <= s_tdata;
			flag_q <= s_tuser;
		end
		if (state_q == ST_SCAN) begin
			if (rep_or.hit) begin
				hit_slot_q <= idx_q;
				hit_rank_q <= rank_or;
			end
			if (rep_or.free && !free_found_q) begin
				free_slot_q <= idx_q;
			end
		end
		if (state_q == ST_UPDATE && out_free) begin
			out_hit_q  <= hit_found_q;
			out_data_q <= OUT_DATA_W'({
				(hit_found_q ? miss_cnt_q : miss_next),
				(hit_found_q ? hit_next : hit_cnt_q),
				evict_ext[EVICT_W-1:0],
				slot_ext[SLOT_OUT_W-1:0]
			});
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_hit_q;

`ifndef SYNTH
	a_miss_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && !hit_found_q) |-> free_found_q)
		else $error("Miss reached update without a free slot.");
	a_scan_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> $onehot(tok[ENTRIES:1]))
		else $error("Scan token is not held by exactly one cell.");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[12:6] == '0))
		else $error("Hit result reports evicted entries.");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && out_free) |=>
		(hit_cnt_q + miss_cnt_q == $past(hit_cnt_q) + $past(miss_cnt_q) + CNT_W'(1)))
		else $error("Lookup counters did not advance by one.");
`endif

endmodule

// ===== rtl/ldc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU descriptor cache entry cell
// Holds one entry's key, valid bit and recency rank, and passes the scan
// token to its neighbor every cycle.
// ----------------------------------------------------------------------------
module ldc_cell #(
	parameter int unsigned RW  = 6,
	parameter int unsigned SW  = 6,
	parameter int unsigned IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ldc_pkg::cell_cmd_t       cmd,
	input  logic [ldc_pkg::KEY_W-1:0] key,
	input  logic                     flag,
	input  logic [RW-1:0]            hit_rank,
	input  logic [RW-1:0]            cap_m1,
	input  logic [SW-1:0]            wr_slot,
	input  logic                     tok_in,
	output logic                     tok_out,
	output ldc_pkg::cell_rep_t       rep,
	output logic [RW-1:0]            rep_rank
);
	import ldc_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic             flag_q;
	logic             valid_q;
	logic [RW-1:0]    rank_q;
	logic             match_q;
	logic             tok_q;
	logic             keep;

	assign keep = valid_q && (rank_q < cap_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
			match_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (cmd.compare) begin
				match_q <= valid_q && (key_q == key) && (flag_q == flag);
			end
			case (cmd.op)
				OP_HIT: begin
					if (match_q) begin
						rank_q <= '0;
					end else if (valid_q && rank_q < hit_rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				OP_MISS: begin
					if (wr_slot == SW'(IDX)) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end else if (valid_q && !keep) begin
						valid_q <= 1'b0;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MISS && wr_slot == SW'(IDX)) begin
			key_q  <= key;
			flag_q <= flag;
		end
	end

	assign tok_out   = tok_q;
	assign rep.hit   = tok_q && match_q;
	assign rep.free  = tok_q && !keep;
	assign rep.evict = tok_q && valid_q && !keep;
	assign rep_rank  = (tok_q && match_q) ? rank_q : '0;

endmodule
